[rtl/core/msd_pkg.sv]
// MFM sector deframer package: types, codes and the CRC-CCITT byte step.
// Used by every module of the deframer; depends on nothing.
package msd_pkg;

    localparam int HEADER_LEN_DEF   = 12;
    localparam int DATA_TRAILER_DEF = 4;
    localparam int TDATA_W          = 48;

    localparam logic [15:0] SYNC_CELLS = 16'h4489;
    localparam logic [7:0]  MARK_DAM   = 8'hF8;
    localparam logic [7:0]  MARK_DDAM  = 8'hFB;
    localparam logic [7:0]  MARK_IDAM  = 8'hFE;
    localparam logic [7:0]  SYNC_BYTE  = 8'hA1;

    localparam logic [9:0] SHORT_MIN_RST = 10'd15;
    localparam logic [9:0] MID_MIN_RST   = 10'd25;
    localparam logic [9:0] LONG_MIN_RST  = 10'd35;
    localparam logic [9:0] LONG_MAX_RST  = 10'd45;

    localparam logic [1:0] REG_SHORT_MIN = 2'd0;
    localparam logic [1:0] REG_MID_MIN   = 2'd1;
    localparam logic [1:0] REG_LONG_MIN  = 2'd2;
    localparam logic [1:0] REG_LONG_MAX  = 2'd3;

    localparam logic [2:0] KIND_SYNC     = 3'd0;
    localparam logic [2:0] KIND_HDR_GOOD = 3'd1;
    localparam logic [2:0] KIND_HDR_BAD  = 3'd2;
    localparam logic [2:0] KIND_DATA     = 3'd3;
    localparam logic [2:0] KIND_UNEXP    = 3'd4;
    localparam logic [2:0] KIND_UNKNOWN  = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MARK,
        ST_HEADER,
        ST_DATA
    } block_state_t;

    typedef enum logic {
        CT_IDLE,
        CT_SCAN
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_pending;
        logic emit_pending;
        logic out_busy;
    } ctrl_status_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] v);
        logic [15:0] c;
        c = crc ^ {v, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

[rtl/core/msd_ctrl.sv]
// Controller of the MFM sector deframer: takes an item, then steps the
// cell scan one pass per cycle unless a result waits. Depends on msd_pkg.
module msd_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  msd_pkg::ctrl_status_t status,
    output msd_pkg::ctrl_cmd_t    cmd
);

    msd_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= msd_pkg::CT_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            msd_pkg::CT_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = msd_pkg::CT_SCAN;
                end
            end
            msd_pkg::CT_SCAN:
            begin
                if (!status.scan_pending)
                    state_next = msd_pkg::CT_IDLE;
                // hold the pass while its result has no slot
                else if (!(status.emit_pending && status.out_busy))
                    cmd.step = 1'b1;
            end
            default: state_next = msd_pkg::CT_IDLE;
        endcase
    end

endmodule

[rtl/core/msd_datapath.sv]
// Datapath of the MFM sector deframer: window compares, cell shifter,
// byte decode, header CRC, field counters and the output register. Uses msd_pkg.
module msd_datapath
#(
    parameter int HEADER_LEN   = msd_pkg::HEADER_LEN_DEF,
    parameter int DATA_TRAILER = msd_pkg::DATA_TRAILER_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  msd_pkg::ctrl_cmd_t          cmd,
    output msd_pkg::ctrl_status_t       status,
    input  logic [15:0]                 interval_ticks,
    input  logic                        cfg_valid,
    input  logic [1:0]                  cfg_index,
    input  logic [9:0]                  cfg_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [2:0]                  out_kind,
    output logic [msd_pkg::TDATA_W-1:0] out_data,
    output logic                        out_last
);

    localparam logic [10:0] HDR_END = 11'(HEADER_LEN);
    localparam logic [10:0] TRAILER = 11'(DATA_TRAILER);
    localparam logic [15:0] SYNC_CRC = msd_pkg::crc_byte(16'hFFFF, msd_pkg::SYNC_BYTE);

    logic [9:0] short_min_reg, mid_min_reg, long_min_reg, long_max_reg;

    logic [18:0] shifter_reg, shifter_next;
    logic [4:0]  count_reg, count_next;
    msd_pkg::block_state_t bstate_reg, bstate_next;
    logic [2:0]  bitc_reg, bitc_next;
    logic [7:0]  asm_reg, asm_next;
    logic [10:0] fp_reg, fp_next;
    logic [7:0]  hdr_reg [6];
    logic [7:0]  hdr_eff [6];
    logic [5:0]  hdr_we;
    logic [15:0] crc_reg, crc_next;
    logic        armed_reg, armed_next;
    logic [11:0] cyl_reg, cyl_next;
    logic [3:0]  head_reg, head_next;
    logic [7:0]  sec_reg, sec_next;
    logic [1:0]  size_reg, size_next;

    logic        emit;
    logic [2:0]  e_kind;
    logic [7:0]  e_byte;
    logic [10:0] e_index;
    logic        e_last;

    logic        out_valid_reg;
    logic [2:0]  kind_reg;
    logic [7:0]  byte_reg;
    logic [10:0] index_reg;
    logic [11:0] o_cyl_reg;
    logic [3:0]  o_head_reg;
    logic [7:0]  o_sec_reg;
    logic [1:0]  o_size_reg;
    logic        last_reg;

    logic [2:0]  ncells;
    logic [15:0] top;
    logic        bit_in;
    logic [10:0] fp_inc;
    logic [10:0] data_len;
    logic        good;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_min_reg <= msd_pkg::SHORT_MIN_RST;
            mid_min_reg   <= msd_pkg::MID_MIN_RST;
            long_min_reg  <= msd_pkg::LONG_MIN_RST;
            long_max_reg  <= msd_pkg::LONG_MAX_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                msd_pkg::REG_SHORT_MIN: short_min_reg <= cfg_data;
                msd_pkg::REG_MID_MIN:   mid_min_reg   <= cfg_data;
                msd_pkg::REG_LONG_MIN:  long_min_reg  <= cfg_data;
                msd_pkg::REG_LONG_MAX:  long_max_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // first matching window wins
    always_comb
    begin
        priority if (interval_ticks > {6'd0, short_min_reg} && interval_ticks < {6'd0, mid_min_reg})
            ncells = 3'd2;
        else if (interval_ticks > {6'd0, mid_min_reg} && interval_ticks < {6'd0, long_min_reg})
            ncells = 3'd3;
        else if (interval_ticks > {6'd0, long_min_reg} && interval_ticks < {6'd0, long_max_reg})
            ncells = 3'd4;
        else
            ncells = 3'd0;
    end

    always_comb
    begin
        unique case (count_reg[1:0])
            2'd0:    top = shifter_reg[15:0];
            2'd1:    top = shifter_reg[16:1];
            2'd2:    top = shifter_reg[17:2];
            default: top = shifter_reg[18:3];
        endcase
    end

    assign bit_in   = !shifter_reg[count_reg - 5'd1] && shifter_reg[count_reg - 5'd2];
    assign fp_inc   = fp_reg + 11'd1;
    assign data_len = (11'd128 << size_reg) + TRAILER;

    always_comb
    begin
        for (int i = 0; i < 6; i++)
            hdr_eff[i] = (fp_reg == 11'(i)) ? asm_next : hdr_reg[i];
    end

    assign good = hdr_eff[4] == crc_reg[15:8] && hdr_eff[5] == crc_reg[7:0];

    assign status.scan_pending = count_reg >= 5'd16 && count_reg <= 5'd19;
    assign status.emit_pending = emit;
    assign status.out_busy     = out_valid_reg && !out_ready;

    always_comb
    begin
        shifter_next = shifter_reg;
        count_next   = count_reg;
        bstate_next  = bstate_reg;
        bitc_next    = bitc_reg;
        asm_next     = asm_reg;
        fp_next      = fp_reg;
        crc_next     = crc_reg;
        armed_next   = armed_reg;
        cyl_next     = cyl_reg;
        head_next    = head_reg;
        sec_next     = sec_reg;
        size_next    = size_reg;
        hdr_we       = '0;
        emit         = 1'b0;
        e_kind       = msd_pkg::KIND_SYNC;
        e_byte       = 8'd0;
        e_index      = 11'd0;
        e_last       = 1'b0;

        if (cmd.load)
        begin
            if (ncells != 3'd0)
            begin
                shifter_next = (shifter_reg << ncells) | 19'd1;
                count_next   = count_reg + {2'd0, ncells};
            end
        end
        else if (status.scan_pending)
        begin
            if (bstate_reg == msd_pkg::ST_IDLE)
            begin
                if (top == msd_pkg::SYNC_CELLS)
                begin
                    count_next  = count_reg - 5'd16;
                    bstate_next = msd_pkg::ST_MARK;
                    asm_next    = 8'd0;
                    bitc_next   = 3'd0;
                    fp_next     = 11'd0;
                    crc_next    = SYNC_CRC;
                    emit        = 1'b1;
                    e_kind      = msd_pkg::KIND_SYNC;
                end
                else
                    count_next = count_reg - 5'd1;
            end
            else
            begin
                count_next = count_reg - 5'd2;
                asm_next   = {asm_reg[6:0], bit_in};
                bitc_next  = bitc_reg + 3'd1;
                if (bitc_reg == 3'd7)
                begin
                    unique case (bstate_reg)
                        msd_pkg::ST_MARK:
                        begin
                            if (asm_next == msd_pkg::MARK_DAM || asm_next == msd_pkg::MARK_DDAM)
                            begin
                                if (armed_reg)
                                begin
                                    bstate_next = msd_pkg::ST_DATA;
                                    fp_next     = 11'd0;
                                end
                                else
                                begin
                                    bstate_next = msd_pkg::ST_IDLE;
                                    emit        = 1'b1;
                                    e_kind      = msd_pkg::KIND_UNEXP;
                                end
                            end
                            else if (asm_next == msd_pkg::MARK_IDAM)
                            begin
                                bstate_next = msd_pkg::ST_HEADER;
                                crc_next    = msd_pkg::crc_byte(crc_reg, msd_pkg::MARK_IDAM);
                            end
                            else
                            begin
                                bstate_next = msd_pkg::ST_IDLE;
                                armed_next  = 1'b0;
                                emit        = 1'b1;
                                e_kind      = msd_pkg::KIND_UNKNOWN;
                            end
                        end
                        msd_pkg::ST_HEADER:
                        begin
                            for (int i = 0; i < 6; i++)
                                hdr_we[i] = fp_reg == 11'(i);
                            if (fp_reg < 11'd4)
                                crc_next = msd_pkg::crc_byte(crc_reg, asm_next);
                            fp_next = fp_inc;
                            if (fp_inc >= HDR_END)
                            begin
                                size_next = (hdr_eff[3] > 8'd3) ? 2'd3 : hdr_eff[3][1:0];
                                if (good)
                                begin
                                    cyl_next   = {hdr_eff[1][7:4], hdr_eff[0]};
                                    head_next  = hdr_eff[1][3:0];
                                    sec_next   = hdr_eff[2];
                                    armed_next = 1'b1;
                                end
                                else
                                begin
                                    cyl_next   = 12'd0;
                                    head_next  = 4'd0;
                                    sec_next   = 8'd0;
                                    armed_next = 1'b0;
                                end
                                bstate_next = msd_pkg::ST_IDLE;
                                emit        = 1'b1;
                                e_kind      = good ? msd_pkg::KIND_HDR_GOOD
                                                   : msd_pkg::KIND_HDR_BAD;
                            end
                        end
                        msd_pkg::ST_DATA:
                        begin
                            fp_next = fp_inc;
                            emit    = 1'b1;
                            e_kind  = msd_pkg::KIND_DATA;
                            e_byte  = asm_next;
                            e_index = fp_reg;
                            e_last  = fp_inc >= data_len;
                            if (e_last)
                                bstate_next = msd_pkg::ST_IDLE;
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shifter_reg <= '0;
            count_reg   <= '0;
            bstate_reg  <= msd_pkg::ST_IDLE;
            bitc_reg    <= '0;
            asm_reg     <= '0;
            fp_reg      <= '0;
            crc_reg     <= 16'hFFFF;
            armed_reg   <= 1'b0;
            cyl_reg     <= '0;
            head_reg    <= '0;
            sec_reg     <= '0;
            size_reg    <= '0;
        end
        else if (cmd.load || cmd.step)
        begin
            shifter_reg <= shifter_next;
            count_reg   <= count_next;
            bstate_reg  <= bstate_next;
            bitc_reg    <= bitc_next;
            asm_reg     <= asm_next;
            fp_reg      <= fp_next;
            crc_reg     <= crc_next;
            armed_reg   <= armed_next;
            cyl_reg     <= cyl_next;
            head_reg    <= head_next;
            sec_reg     <= sec_next;
            size_reg    <= size_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 6; i++)
        begin
            if (cmd.step && hdr_we[i])
                hdr_reg[i] <= asm_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.step && emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step && emit)
        begin
            kind_reg   <= e_kind;
            byte_reg   <= e_byte;
            index_reg  <= e_index;
            o_cyl_reg  <= cyl_next;
            o_head_reg <= head_next;
            o_sec_reg  <= sec_next;
            o_size_reg <= size_next;
            last_reg   <= e_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = kind_reg;
    assign out_last  = last_reg;
    assign out_data  = {3'd0, o_size_reg, o_sec_reg, o_head_reg, o_cyl_reg, index_reg, byte_reg};

endmodule

[rtl/core/mfm_sector_deframer.sv]
// MFM sector deframer top level: flux intervals in, sync/header/data items out.
// Ties msd_ctrl and msd_datapath together; uses msd_pkg.
//
// Usage: each item on the s_ side is one flux interval in ticks. It is sorted
// into 2, 3 or 4 MFM cells, or dropped, against the four window registers.
// These are written over the cfg_ channel (index 0 short_min, 1 mid_min,
// 2 long_min, 3 long_max); the user must write them only while the block is
// idle, as the block does not enforce it. The m_ side carries one item for
// each sync, header verdict, mark error or decoded data byte; tuser is the
// kind, tlast marks the final byte of a data field.
// Timing: an item is accepted, scan passes run (one cell hunted, the sync cells
// taken or one cell pair decoded), then the block returns to accept; a result
// appears in the output register on the cycle after the pass that makes it.
// Reset clears the shifter, the state and the window registers to 15/25/35/45.
// When the receiver stalls with a result held, a pass that would make another
// result waits, and the input stays blocked until that pass has gone through.
module mfm_sector_deframer
#(
    parameter int HEADER_LEN   = msd_pkg::HEADER_LEN_DEF,
    parameter int DATA_TRAILER = msd_pkg::DATA_TRAILER_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [15:0]                 s_tdata,   // interval_ticks
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // data_byte, byte_index, cylinder, head_num, sector_num, size_code, zero pad
    output logic [msd_pkg::TDATA_W-1:0] m_tdata,
    output logic [2:0]                  m_tuser,   // kind
    output logic                        m_tlast,   // last
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [9:0]                  cfg_data
);

    msd_pkg::ctrl_cmd_t    cmd;
    msd_pkg::ctrl_status_t status;

    assign cfg_ready = 1'b1;

    msd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    msd_datapath
    #(
        .HEADER_LEN   (HEADER_LEN),
        .DATA_TRAILER (DATA_TRAILER)
    )
    u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .interval_ticks (s_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_kind       (m_tuser),
        .out_data       (m_tdata),
        .out_last       (m_tlast)
    );

endmodule

[rtl/core/msd_checker.sv]
// Port checker for the MFM sector deframer, bound to the top level.
// Sees the top-level ports only; uses msd_pkg for kind codes.
module msd_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [msd_pkg::TDATA_W-1:0] m_tdata,
    input logic [2:0]                  m_tuser,
    input logic                        m_tlast
);

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser <= msd_pkg::KIND_UNKNOWN)
        else $error("result kind out of range");

    a_last_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> m_tuser == msd_pkg::KIND_DATA)
        else $error("tlast on a non-data item");

    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != msd_pkg::KIND_DATA) |-> m_tdata[18:0] == 19'd0)
        else $error("byte or index set on a non-data item");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled item changed");

endmodule

bind mfm_sector_deframer msd_checker u_msd_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

[bench/tb.sv]
// Self-checking bench for mfm_sector_deframer: MFM-encoded sectors and noise intervals in,
// sync/header/data items out, compared against an in-bench model of the deframer.
// Depends on msd_pkg and the deframer RTL.
module tb;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data_byte;
        logic [10:0] byte_index;
        logic [11:0] cylinder;
        logic [3:0]  head_num;
        logic [7:0]  sector_num;
        logic [1:0]  size_code;
        logic        last;
    } frame_item_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [15:0]                   s_tdata = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [msd_pkg::TDATA_W-1:0]   m_tdata;
    logic [2:0]                    m_tuser;
    logic                          m_tlast;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [1:0]                    cfg_index = '0;
    logic [9:0]                    cfg_data = '0;

    mfm_sector_deframer u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end

    // ---------------- deframer model ----------------
    logic [9:0]            win_short = msd_pkg::SHORT_MIN_RST;
    logic [9:0]            win_mid   = msd_pkg::MID_MIN_RST;
    logic [9:0]            win_long  = msd_pkg::LONG_MIN_RST;
    logic [9:0]            win_max   = msd_pkg::LONG_MAX_RST;
    logic [31:0]           cells = '0;
    int                    cell_cnt = 0;
    msd_pkg::block_state_t fsm = msd_pkg::ST_IDLE;
    int                    bit_cnt = 0;
    logic [7:0]            shift_byte = '0;
    int                    field_pos = 0;
    logic [7:0]            hdr [6] = '{default: 8'h00};
    logic [15:0]           hdr_crc = 16'hFFFF;
    logic                  armed = 1'b0;
    logic [11:0]           cur_cyl = '0;
    logic [3:0]            cur_head = '0;
    logic [7:0]            cur_sec = '0;
    logic [1:0]            cur_size = '0;
    int                    step_results;
    frame_item_t           expected_items [$];
    int                    errors = 0;

    function automatic logic [15:0] ccitt_step(input logic [15:0] crc, input logic [7:0] v);
        logic [15:0] c;
        c = crc ^ {v, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ 16'h1021;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

    task automatic push_item(input logic [2:0] kind, input logic [7:0] b,
                             input logic [10:0] idx, input logic last);
        frame_item_t it;
        if (step_results >= 2)
            return;
        it = '{kind, b, idx, cur_cyl, cur_head, cur_sec, cur_size, last};
        expected_items.push_back(it);
        step_results++;
    endtask

    task automatic finish_byte(input logic [7:0] v);
        logic good;
        int len;
        int idx;
        case (fsm)
            msd_pkg::ST_MARK:
            begin
                if (v == msd_pkg::MARK_DAM || v == msd_pkg::MARK_DDAM)
                begin
                    if (armed)
                    begin
                        fsm = msd_pkg::ST_DATA;
                        field_pos = 0;
                    end
                    else
                    begin
                        fsm = msd_pkg::ST_IDLE;
                        push_item(msd_pkg::KIND_UNEXP, 8'h00, 11'd0, 1'b0);
                    end
                end
                else if (v == msd_pkg::MARK_IDAM)
                begin
                    fsm = msd_pkg::ST_HEADER;
                    hdr_crc = ccitt_step(hdr_crc, msd_pkg::MARK_IDAM);
                end
                else
                begin
                    fsm = msd_pkg::ST_IDLE;
                    armed = 1'b0;
                    push_item(msd_pkg::KIND_UNKNOWN, 8'h00, 11'd0, 1'b0);
                end
            end
            msd_pkg::ST_HEADER:
            begin
                if (field_pos < 6)
                    hdr[field_pos] = v;
                if (field_pos < 4)
                    hdr_crc = ccitt_step(hdr_crc, v);
                field_pos = (field_pos + 1) & 11'h7FF;
                if (field_pos >= msd_pkg::HEADER_LEN_DEF)
                begin
                    good = (hdr[4] == hdr_crc[15:8]) && (hdr[5] == hdr_crc[7:0]);
                    cur_size = (hdr[3] > 8'd3) ? 2'd3 : hdr[3][1:0];
                    if (good)
                    begin
                        cur_cyl = {hdr[1][7:4], hdr[0]};
                        cur_head = hdr[1][3:0];
                        cur_sec = hdr[2];
                        armed = 1'b1;
                    end
                    else
                    begin
                        cur_cyl = '0;
                        cur_head = '0;
                        cur_sec = '0;
                        armed = 1'b0;
                    end
                    fsm = msd_pkg::ST_IDLE;
                    push_item(good ? msd_pkg::KIND_HDR_GOOD : msd_pkg::KIND_HDR_BAD,
                              8'h00, 11'd0, 1'b0);
                end
            end
            msd_pkg::ST_DATA:
            begin
                idx = field_pos;
                len = (128 << cur_size) + msd_pkg::DATA_TRAILER_DEF;
                field_pos = (field_pos + 1) & 11'h7FF;
                push_item(msd_pkg::KIND_DATA, v, idx[10:0], field_pos >= len);
                if (field_pos >= len)
                    fsm = msd_pkg::ST_IDLE;
            end
            default: ;
        endcase
    endtask

    task automatic predict_interval(input logic [15:0] d);
        int k;
        logic c0;
        logic c1;
        step_results = 0;
        k = 0;
        if (d > win_short && d < win_mid)
            k = 2;
        else if (d > win_mid && d < win_long)
            k = 3;
        else if (d > win_long && d < win_max)
            k = 4;
        if (k != 0)
        begin
            cells = ((cells << k) | 32'd1) & 32'h7FFFF;
            cell_cnt += k;
        end
        while (cell_cnt >= 16 && cell_cnt <= 19)
        begin
            if (fsm == msd_pkg::ST_IDLE)
            begin
                if (((cells >> (cell_cnt - 16)) & 32'hFFFF) == {16'h0, msd_pkg::SYNC_CELLS})
                begin
                    cell_cnt -= 16;
                    fsm = msd_pkg::ST_MARK;
                    shift_byte = '0;
                    bit_cnt = 0;
                    field_pos = 0;
                    hdr_crc = ccitt_step(16'hFFFF, msd_pkg::SYNC_BYTE);
                    push_item(msd_pkg::KIND_SYNC, 8'h00, 11'd0, 1'b0);
                end
                else
                    cell_cnt -= 1;
            end
            else
            begin
                c0 = cells[cell_cnt - 1];
                c1 = cells[cell_cnt - 2];
                cell_cnt -= 2;
                shift_byte = {shift_byte[6:0], (!c0 && c1)};
                if (bit_cnt >= 7)
                begin
                    bit_cnt = 0;
                    cells = cells & ((32'd1 << cell_cnt) - 1);
                    finish_byte(shift_byte);
                end
                else
                    bit_cnt++;
            end
            cells = cells & ((32'd1 << cell_cnt) - 1);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            predict_interval(s_tdata);
    end

    // Compare every accepted result with the oldest prediction
    always @(posedge clk)
    begin
        frame_item_t got;
        frame_item_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tuser, m_tdata[7:0], m_tdata[18:8], m_tdata[30:19], m_tdata[34:31],
                    m_tdata[42:35], m_tdata[44:43], m_tlast};
            if (expected_items.size() == 0)
            begin
                $display("%0t: unexpected item, actual %h", $realtime, got);
                errors++;
            end
            else
            begin
                want = expected_items.pop_front();
                if (got !== want || m_tdata[47:45] !== 3'b000)
                begin
                    $display("%0t: mismatch kind/byte/idx/cyl/head/sec/size/last", $realtime);
                    $display("    expected %0d %h %0d %h %h %h %0d %b", want.kind,
                             want.data_byte, want.byte_index, want.cylinder, want.head_num,
                             want.sector_num, want.size_code, want.last);
                    $display("    actual   %0d %h %0d %h %h %h %0d %b (pad %b)", got.kind,
                             got.data_byte, got.byte_index, got.cylinder, got.head_num,
                             got.sector_num, got.size_code, got.last, m_tdata[47:45]);
                    errors++;
                end
            end
        end
    end

    // ---------------- receiver ----------------
    logic steady = 1'b0;
    logic hold_tog = 1'b0;
    logic hold_ack = 1'b0;
    int   stall_left = 0;

    always @(posedge clk)
    begin
        int r;
        if (rst_n)
        begin
            if (hold_tog != hold_ack)
            begin
                hold_ack <= hold_tog;
                stall_left <= 400;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                r = $urandom_range(0, 99);
                if (!steady && r < 25)
                    stall_left <= (r < 22) ? $urandom_range(1, 3) : $urandom_range(15, 60);
            end
        end
    end

    // ---------------- sender ----------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_interval(input logic [15:0] v);
        int gap;
        s_tdata <= v;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop the offer so that nothing is taken twice while the block drains
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        wait (expected_items.size() == 0);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [9:0] v);
        s_tvalid <= 1'b0;
        cfg_index <= idx;
        cfg_data <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            msd_pkg::REG_SHORT_MIN: win_short = v;
            msd_pkg::REG_MID_MIN:   win_mid = v;
            msd_pkg::REG_LONG_MIN:  win_long = v;
            default:                win_max = v;
        endcase
        @(posedge clk);
    endtask

    task automatic set_windows(input logic [9:0] a, input logic [9:0] b,
                               input logic [9:0] c, input logic [9:0] d);
        wait_drained();
        write_reg(msd_pkg::REG_SHORT_MIN, a);
        write_reg(msd_pkg::REG_MID_MIN, b);
        write_reg(msd_pkg::REG_LONG_MIN, c);
        write_reg(msd_pkg::REG_LONG_MAX, d);
    endtask

    // ---------------- MFM encoder ----------------
    bit cell_q [$];
    bit prev_data = 1'b0;
    int run_len = 0;

    function automatic logic [15:0] ticks_for(input int k);
        if (k == 2)
            return 16'($urandom_range(win_short + 1, win_mid - 1));
        if (k == 3)
            return 16'($urandom_range(win_mid + 1, win_long - 1));
        return 16'($urandom_range(win_long + 1, win_max - 1));
    endfunction

    task automatic enc_byte(input logic [7:0] b);
        for (int i = 7; i >= 0; i--)
        begin
            cell_q.push_back(!(prev_data || b[i]));
            cell_q.push_back(b[i]);
            prev_data = b[i];
        end
    endtask

    task automatic enc_sync();
        for (int i = 15; i >= 0; i--)
            cell_q.push_back(msd_pkg::SYNC_CELLS[i]);
        prev_data = 1'b1;
    endtask

    task automatic enc_gap(input int n);
        repeat (n) enc_byte(8'h4E);
    endtask

    // Turn queued cells into intervals; a run outside 2..4 cells is dropped
    task automatic flush_cells();
        bit c;
        while (cell_q.size() > 0)
        begin
            c = cell_q.pop_front();
            run_len++;
            if (c)
            begin
                if (run_len >= 2 && run_len <= 4)
                    send_interval(ticks_for(run_len));
                run_len = 0;
            end
        end
    endtask

    task automatic enc_header(input logic good, input logic [7:0] size_byte);
        logic [7:0]  id [4];
        logic [15:0] crc;
        id[0] = 8'($urandom);
        id[1] = 8'($urandom);
        id[2] = 8'($urandom);
        id[3] = size_byte;
        crc = ccitt_step(ccitt_step(16'hFFFF, msd_pkg::SYNC_BYTE), msd_pkg::MARK_IDAM);
        for (int i = 0; i < 4; i++)
            crc = ccitt_step(crc, id[i]);
        if (!good)
            crc = crc ^ (16'd1 << $urandom_range(0, 15));
        enc_gap(1);
        enc_sync();
        enc_byte(msd_pkg::MARK_IDAM);
        for (int i = 0; i < 4; i++)
            enc_byte(id[i]);
        enc_byte(crc[15:8]);
        enc_byte(crc[7:0]);
        repeat (msd_pkg::HEADER_LEN_DEF - 6) enc_byte(8'h55);
    endtask

    // A few random bytes up front, then mostly long runs to keep a full field short
    task automatic enc_data(input int nbytes);
        enc_gap(1);
        enc_sync();
        enc_byte($urandom_range(0, 1) ? msd_pkg::MARK_DAM : msd_pkg::MARK_DDAM);
        for (int i = 0; i < nbytes; i++)
            enc_byte((i < 4 || $urandom_range(0, 15) == 0) ? 8'($urandom) : 8'h55);
    endtask

    task automatic send_sector(input logic good, input logic [7:0] size_byte,
                               input logic with_data);
        enc_header(good, size_byte);
        if (with_data)
            enc_data((128 << ((size_byte > 8'd3) ? 3 : size_byte))
                     + msd_pkg::DATA_TRAILER_DEF);
        enc_gap(1);
        flush_cells();
    endtask

    task automatic send_bad_mark();
        logic [7:0] m;
        m = 8'($urandom);
        while (m == msd_pkg::MARK_DAM || m == msd_pkg::MARK_DDAM || m == msd_pkg::MARK_IDAM)
            m = 8'($urandom);
        enc_gap(1);
        enc_sync();
        enc_byte(m);
        enc_gap(1);
        flush_cells();
    endtask

    task automatic send_noise(input int n);
        repeat (n)
        begin
            if ($urandom_range(0, 2) == 0)
                send_interval(16'($urandom));
            else
                send_interval(16'($urandom_range(0, 1100)));
        end
    endtask

    function automatic logic [9:0] rnd_base();
        return 10'($urandom_range(0, 200));
    endfunction

    // ---------------- tests ----------------
    task automatic test_interval_extremes();
        logic [15:0] pts [14] = '{16'd0, 16'd15, 16'd16, 16'd24, 16'd25, 16'd26, 16'd34,
                                  16'd35, 16'd36, 16'd44, 16'd45, 16'd46, 16'd65535, 16'hAAAA};
        foreach (pts[i])
            send_interval(pts[i]);
        send_interval(16'h5555);
    endtask

    task automatic test_marks();
        send_bad_mark();
        enc_data(4);
        enc_gap(1);
        flush_cells();
        send_sector(1'b0, 8'd2, 1'b0);
    endtask

    task automatic test_window_settings();
        logic [9:0] a;
        set_windows(10'd0, 10'd0, 10'd0, 10'd0);
        send_noise(8);
        set_windows(10'd1023, 10'd1023, 10'd1023, 10'd1023);
        send_noise(8);
        set_windows(10'd40, 10'd10, 10'd30, 10'd20);
        send_noise(10);
        set_windows(10'd20, 10'd40, 10'd30, 10'd60);
        send_noise(10);
        a = rnd_base();
        set_windows(a, a + 10'($urandom_range(2, 50)) + 10'd2, a + 10'd110, a + 10'd160);
        send_sector(1'b1, 8'd3, 1'b0);
        set_windows(msd_pkg::SHORT_MIN_RST, msd_pkg::MID_MIN_RST, msd_pkg::LONG_MIN_RST,
                    msd_pkg::LONG_MAX_RST);
    endtask

    task automatic test_size_saturation();
        send_sector(1'b1, 8'd200, 1'b0);
    endtask

    // Arm with a good header, then stall the receiver while a full data field streams in
    task automatic test_backpressure();
        send_sector(1'b1, 8'd0, 1'b0);
        hold_tog <= ~hold_tog;
        enc_data(128 + msd_pkg::DATA_TRAILER_DEF);
        enc_gap(1);
        flush_cells();
    endtask

    task automatic test_steady_stream();
        wait_drained();
        steady <= 1'b1;
        send_noise(30);
        wait_drained();
        steady <= 1'b0;
    endtask

    task automatic test_random_traffic();
        int r;
        for (int n = 0; n < 3; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                send_sector($urandom_range(0, 5) != 0, 8'($urandom_range(0, 5)), 1'b0);
            else if (r < 60)
                send_bad_mark();
            else if (r < 80)
            begin
                enc_data($urandom_range(1, 6));
                enc_gap(1);
                flush_cells();
            end
            else
                send_noise($urandom_range(5, 15));
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_interval_extremes();
        test_marks();
        test_window_settings();
        test_size_saturation();
        test_backpressure();
        test_steady_stream();
        test_random_traffic();
        s_tvalid <= 1'b0;
        wait (expected_items.size() == 0);
        repeat (50) @(posedge clk);
        if (errors == 0 && expected_items.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[files.f]
rtl/core/msd_pkg.sv
rtl/core/msd_ctrl.sv
rtl/core/msd_datapath.sv
rtl/core/mfm_sector_deframer.sv
rtl/core/msd_checker.sv
bench/tb.sv
